/* rtl/core/ipfmt_pkg.sv */
// Shared types and constants for the socket address text formatter.
// Used by the front, queue, back and top level; depends on nothing.

package ipfmt_pkg;

  localparam int NUM_HEXTETS         = 8;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic        family;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [15:0] port_number;
    logic [2:0]  run_start;
    logic [3:0]  run_len;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OPEN,
    S_LEAD,
    S_HEX,
    S_COLON_END,
    S_CLOSE,
    S_PCOLON,
    S_CONV,
    S_DEC,
    S_DOT
  } back_state_t;

endpackage

/* rtl/core/ipfmt_front.sv */
// Front stage: accepts socket addresses and finds the first longest zero-hextet run.
// Depends on ipfmt_pkg; feeds ipfmt_queue.

module ipfmt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                family,
  input  logic [63:0]         address_high,
  input  logic [63:0]         address_low,
  input  logic [15:0]         port_number,
  input  logic                item_valid,
  output logic                item_ready,
  output ipfmt_pkg::item_t    entry,
  output logic                entry_valid,
  input  logic                entry_ready
);

  ipfmt_pkg::item_t classified;
  logic             accept;
  logic [3:0]       run;
  logic [3:0]       best_len;
  logic [2:0]       best_start;
  logic [15:0]      hext;

  assign item_ready = !entry_valid || entry_ready;
  assign accept     = item_valid && item_ready;

  always_comb begin
    run        = 4'd0;
    best_len   = 4'd0;
    best_start = 3'd0;
    hext       = 16'd0;
    for (int i = 0; i < ipfmt_pkg::NUM_HEXTETS; i++) begin
      if (i < ipfmt_pkg::NUM_HEXTETS / 2) begin
        hext = address_high[63 - 16 * i -: 16];
      end else begin
        hext = address_low[63 - 16 * (i - ipfmt_pkg::NUM_HEXTETS / 2) -: 16];
      end
      if (hext == 16'd0) begin
        run = run + 4'd1;
        if (run > best_len) begin
          best_len   = run;
          best_start = 3'(i + 1 - int'(run));
        end
      end else begin
        run = 4'd0;
      end
    end
  end

  always_comb begin
    classified.family       = family;
    classified.address_high = address_high;
    classified.address_low  = address_low;
    classified.port_number  = port_number;
    classified.run_start    = best_start;
    classified.run_len      = best_len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (accept) begin
      entry_valid <= 1'b1;
    end else if (entry_ready) begin
      entry_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry <= classified;
    end
  end

endmodule

/* rtl/core/ipfmt_queue.sv */
// Short queue of classified addresses between front and back.
// Depends on ipfmt_pkg.

module ipfmt_queue #(
  parameter int DEPTH = ipfmt_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  ipfmt_pkg::item_t push_item,
  input  logic             push_valid,
  output logic             push_ready,
  output ipfmt_pkg::item_t pop_item,
  output logic             pop_valid,
  input  logic             pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ipfmt_pkg::item_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

/* rtl/core/ipfmt_back.sv */
// Back sequencer: writes one address as ASCII text, one character per transaction.
// Depends on ipfmt_pkg; takes entries from ipfmt_queue.

module ipfmt_back (
  input  logic             clk,
  input  logic             rst,
  input  ipfmt_pkg::item_t entry,
  input  logic             entry_valid,
  output logic             entry_take,
  output logic [7:0]       text_char,
  output logic             last_char,
  output logic             text_valid,
  input  logic             text_ready
);

  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_OPEN  = 8'h5b;
  localparam logic [7:0] CHAR_CLOSE = 8'h5d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] HEX_ALPHA  = 8'd87;
  localparam int         DIGITS_MAX = 5;
  localparam logic [2:0] NUM_LAST_OCTET = 3'd3;
  localparam logic [2:0] NUM_PORT       = 3'd4;
  localparam logic [15:0] RECIP_TEN     = 16'd52429;

  ipfmt_pkg::back_state_t state, state_next;
  ipfmt_pkg::item_t       cur, cur_next;
  logic [3:0]             idx, idx_next;
  logic [1:0]             nib, nib_next;
  logic [2:0]             dec_sel, dec_sel_next;
  logic [15:0]            dval, dval_next;
  logic [2:0]             dcnt, dcnt_next;
  logic [3:0]             dig [DIGITS_MAX];
  logic                   dig_we;

  logic [15:0] hext [ipfmt_pkg::NUM_HEXTETS];
  logic [15:0] cur_hext;
  logic [3:0]  nib_val;
  logic        compress;
  logic        at_run;
  logic [3:0]  run_end;
  logic [31:0] prod;
  logic [15:0] quot;
  logic [15:0] quot_ten;
  logic [15:0] rem_full;
  logic [2:0]  dtop;
  logic        go;
  logic        emit;
  logic [7:0]  char_sel;
  logic        last_sel;

  function automatic logic [1:0] top_nib(input logic [15:0] h);
    logic [1:0] p;
    if (h[15:12] != 4'd0) begin
      p = 2'd3;
    end else if (h[11:8] != 4'd0) begin
      p = 2'd2;
    end else if (h[7:4] != 4'd0) begin
      p = 2'd1;
    end else begin
      p = 2'd0;
    end
    return p;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n > 4'd9) begin
      c = {4'd0, n} + HEX_ALPHA;
    end else begin
      c = {4'd0, n} + CHAR_ZERO;
    end
    return c;
  endfunction

  function automatic logic [7:0] octet_of(input logic [63:0] lo, input logic [2:0] sel);
    logic [7:0] o;
    case (sel)
      3'd0:    o = lo[31:24];
      3'd1:    o = lo[23:16];
      3'd2:    o = lo[15:8];
      default: o = lo[7:0];
    endcase
    return o;
  endfunction

  always_comb begin
    for (int i = 0; i < ipfmt_pkg::NUM_HEXTETS / 2; i++) begin
      hext[i]                                = cur.address_high[63 - 16 * i -: 16];
      hext[i + ipfmt_pkg::NUM_HEXTETS / 2]   = cur.address_low[63 - 16 * i -: 16];
    end
  end

  assign cur_hext = hext[idx[2:0]];
  assign compress = cur.run_len >= 4'd2;
  assign at_run   = compress && (idx == {1'b0, cur.run_start});
  assign run_end  = idx + cur.run_len;

  always_comb begin
    case (nib)
      2'd3:    nib_val = cur_hext[15:12];
      2'd2:    nib_val = cur_hext[11:8];
      2'd1:    nib_val = cur_hext[7:4];
      default: nib_val = cur_hext[3:0];
    endcase
  end

  assign prod     = 32'(dval) * 32'(RECIP_TEN);
  assign quot     = {3'd0, prod[31:19]};
  assign quot_ten = (quot << 3) + (quot << 1);
  assign rem_full = dval - quot_ten;
  assign dtop     = dcnt - 3'd1;

  assign go = !text_valid || text_ready;

  always_comb begin
    state_next = state;
    case (state)
      ipfmt_pkg::S_IDLE: begin
        if (entry_valid) begin
          state_next = entry.family ? ipfmt_pkg::S_OPEN : ipfmt_pkg::S_CONV;
        end
      end
      ipfmt_pkg::S_OPEN: begin
        if (go) begin
          state_next = (compress && cur.run_start == 3'd0) ? ipfmt_pkg::S_LEAD
                                                            : ipfmt_pkg::S_HEX;
        end
      end
      ipfmt_pkg::S_LEAD: begin
        if (go) begin
          if (at_run) begin
            state_next = (run_end >= 4'(ipfmt_pkg::NUM_HEXTETS)) ? ipfmt_pkg::S_COLON_END
                                                                  : ipfmt_pkg::S_LEAD;
          end else begin
            state_next = ipfmt_pkg::S_HEX;
          end
        end
      end
      ipfmt_pkg::S_HEX: begin
        if (go && nib == 2'd0) begin
          state_next = (idx == 4'(ipfmt_pkg::NUM_HEXTETS - 1)) ? ipfmt_pkg::S_CLOSE
                                                                : ipfmt_pkg::S_LEAD;
        end
      end
      ipfmt_pkg::S_COLON_END: begin
        if (go) begin
          state_next = ipfmt_pkg::S_CLOSE;
        end
      end
      ipfmt_pkg::S_CLOSE: begin
        if (go) begin
          state_next = ipfmt_pkg::S_PCOLON;
        end
      end
      ipfmt_pkg::S_PCOLON: begin
        if (go) begin
          state_next = ipfmt_pkg::S_CONV;
        end
      end
      ipfmt_pkg::S_CONV: begin
        if (quot == 16'd0) begin
          state_next = ipfmt_pkg::S_DEC;
        end
      end
      ipfmt_pkg::S_DEC: begin
        if (go && dcnt == 3'd1) begin
          if (dec_sel == NUM_PORT) begin
            state_next = ipfmt_pkg::S_IDLE;
          end else if (dec_sel == NUM_LAST_OCTET) begin
            state_next = ipfmt_pkg::S_PCOLON;
          end else begin
            state_next = ipfmt_pkg::S_DOT;
          end
        end
      end
      ipfmt_pkg::S_DOT: begin
        if (go) begin
          state_next = ipfmt_pkg::S_CONV;
        end
      end
      default: state_next = ipfmt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cur_next     = cur;
    idx_next     = idx;
    nib_next     = nib;
    dec_sel_next = dec_sel;
    dval_next    = dval;
    dcnt_next    = dcnt;
    dig_we       = 1'b0;
    entry_take   = 1'b0;
    emit         = 1'b0;
    char_sel     = CHAR_COLON;
    last_sel     = 1'b0;
    case (state)
      ipfmt_pkg::S_IDLE: begin
        entry_take   = entry_valid;
        cur_next     = entry;
        idx_next     = 4'd0;
        nib_next     = top_nib(entry.address_high[63:48]);
        dec_sel_next = 3'd0;
        dcnt_next    = 3'd0;
        dval_next    = {8'd0, entry.address_low[31:24]};
      end
      ipfmt_pkg::S_OPEN: begin
        emit     = go;
        char_sel = CHAR_OPEN;
      end
      ipfmt_pkg::S_LEAD: begin
        emit = go;
        if (at_run) begin
          if (go) begin
            idx_next = run_end;
          end
        end else begin
          nib_next = top_nib(cur_hext);
        end
      end
      ipfmt_pkg::S_HEX: begin
        emit     = go;
        char_sel = hex_char(nib_val);
        if (go) begin
          if (nib == 2'd0) begin
            idx_next = idx + 4'd1;
          end else begin
            nib_next = nib - 2'd1;
          end
        end
      end
      ipfmt_pkg::S_COLON_END: begin
        emit = go;
      end
      ipfmt_pkg::S_CLOSE: begin
        emit     = go;
        char_sel = CHAR_CLOSE;
      end
      ipfmt_pkg::S_PCOLON: begin
        emit         = go;
        dval_next    = cur.port_number;
        dec_sel_next = NUM_PORT;
        dcnt_next    = 3'd0;
      end
      ipfmt_pkg::S_CONV: begin
        dig_we    = 1'b1;
        dcnt_next = dcnt + 3'd1;
        dval_next = quot;
      end
      ipfmt_pkg::S_DEC: begin
        emit     = go;
        char_sel = {4'd0, dig[dtop]} + CHAR_ZERO;
        last_sel = (dcnt == 3'd1) && (dec_sel == NUM_PORT);
        if (go) begin
          dcnt_next = dtop;
        end
      end
      ipfmt_pkg::S_DOT: begin
        emit     = go;
        char_sel = CHAR_DOT;
        if (go) begin
          dec_sel_next = dec_sel + 3'd1;
          dval_next    = {8'd0, octet_of(cur.address_low, dec_sel + 3'd1)};
          dcnt_next    = 3'd0;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ipfmt_pkg::S_IDLE;
      text_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        text_valid <= 1'b1;
      end else if (text_ready) begin
        text_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    idx     <= idx_next;
    nib     <= nib_next;
    dec_sel <= dec_sel_next;
    dval    <= dval_next;
    dcnt    <= dcnt_next;
    if (dig_we) begin
      dig[dcnt] <= rem_full[3:0];
    end
    if (emit) begin
      text_char <= char_sel;
      last_char <= last_sel;
    end
  end

`ifndef SYNTHESIS
  a_dec_has_digit: assert property (@(posedge clk) disable iff (rst)
    state == ipfmt_pkg::S_DEC |-> dcnt != 3'd0)
    else $error("digit pop with empty stack");

  a_conv_room: assert property (@(posedge clk) disable iff (rst)
    state == ipfmt_pkg::S_CONV |-> dcnt < 3'(DIGITS_MAX))
    else $error("digit stack overflow");

  a_hex_index: assert property (@(posedge clk) disable iff (rst)
    state == ipfmt_pkg::S_HEX |-> idx < 4'(ipfmt_pkg::NUM_HEXTETS))
    else $error("hextet index out of range");

  a_lead_sep: assert property (@(posedge clk) disable iff (rst)
    (state == ipfmt_pkg::S_LEAD && !at_run) |-> idx != 4'd0)
    else $error("separator before first hextet");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit && last_sel) |=> state == ipfmt_pkg::S_IDLE)
    else $error("sequencer busy after final character");
`endif

endmodule

/* rtl/core/ip_address_port_text_formatter_top.sv */
// Top level of the socket address text formatter.
// Depends on ipfmt_pkg, ipfmt_front, ipfmt_queue and ipfmt_back.
//
//   channel  handshake                payload
//   address  item_valid / item_ready  family, address_high, address_low, port_number
//   text     text_valid / text_ready  text_char, last_char
//
// The sequencer takes an address from the queue, then writes it one character per
// transaction, with a divide-by-ten step per decimal digit. Reset empties the
// front stage and queue and idles the sequencer. A stalled text channel holds
// the sequencer; the front stage and queue go on taking up to QUEUE_DEPTH + 1
// addresses meanwhile.

module ip_address_port_text_formatter_top #(
  parameter int QUEUE_DEPTH = ipfmt_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        family,
  input  logic [63:0] address_high,
  input  logic [63:0] address_low,
  input  logic [15:0] port_number,
  input  logic        item_valid,
  output logic        item_ready,
  output logic [7:0]  text_char,
  output logic        last_char,
  output logic        text_valid,
  input  logic        text_ready
);

  ipfmt_pkg::item_t front_entry;
  logic             front_valid;
  logic             front_ready;
  ipfmt_pkg::item_t queue_entry;
  logic             queue_valid;
  logic             queue_take;

  ipfmt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .family       (family),
    .address_high (address_high),
    .address_low  (address_low),
    .port_number  (port_number),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .entry        (front_entry),
    .entry_valid  (front_valid),
    .entry_ready  (front_ready)
  );

  ipfmt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (front_entry),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_item   (queue_entry),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_take)
  );

  ipfmt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry       (queue_entry),
    .entry_valid (queue_valid),
    .entry_take  (queue_take),
    .text_char   (text_char),
    .last_char   (last_char),
    .text_valid  (text_valid),
    .text_ready  (text_ready)
  );

endmodule
